@@ src/vrrl_pkg.sv @@
// Package: constants, codes and the boot record table for the variable record ring log.
package vrrl_pkg;

  // Store geometry and record limits
  localparam int STORE_BYTES = 4096;
  localparam int ADDR_W = 12;
  localparam int MSG_MAX = 255;
  localparam logic [7:0] OVERFLOW_MASK = 8'h80;
  localparam logic [7:0] INFO_TYPE = 8'h01;
  localparam int STEP_MAX = STORE_BYTES / 4 + 4;
  localparam int STEP_W = $clog2(STEP_MAX + 1);
  localparam int BOOT_LAST = 24;

  // Action codes (input tuser)
  localparam logic [1:0] ACT_BEGIN = 2'd0;
  localparam logic [1:0] ACT_MSG = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;

  // Status codes (output tuser)
  localparam logic [1:0] STAT_READ = 2'd0;
  localparam logic [1:0] STAT_OPEN = 2'd1;
  localparam logic [1:0] STAT_DONE = 2'd2;
  localparam logic [1:0] STAT_ERR = 2'd3;

  // Boot record: header, "clog initialized", terminator
  function automatic logic [7:0] boot_byte(input logic [4:0] idx);
    logic [7:0] b;
    case (idx)
      5'd0:    b = INFO_TYPE;
      5'd3:    b = 8'h11;
      5'd8:    b = 8'h63;
      5'd9:    b = 8'h6c;
      5'd10:   b = 8'h6f;
      5'd11:   b = 8'h67;
      5'd12:   b = 8'h20;
      5'd13:   b = 8'h69;
      5'd14:   b = 8'h6e;
      5'd15:   b = 8'h69;
      5'd16:   b = 8'h74;
      5'd17:   b = 8'h69;
      5'd18:   b = 8'h61;
      5'd19:   b = 8'h6c;
      5'd20:   b = 8'h69;
      5'd21:   b = 8'h7a;
      5'd22:   b = 8'h65;
      5'd23:   b = 8'h64;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

@@ src/variable_record_ring_log.sv @@
// Top level: ring store of variable length log records with a small placement sequencer.
//
//  channel  | valid / ready               | tuser        | tdata (low bit up)
//  ---------+-----------------------------+--------------+--------------------------------
//  s_axis   | s_axis_tvalid/s_axis_tready | action       | record_type, time_stamp,
//           |                             |              | msg_length, msg_byte, read_addr
//  m_axis   | m_axis_tvalid/m_axis_tready | status       | new_block_pos, oldest_block_pos,
//           |                             |              | read_data
//
// Read: address taken with the beat, data caught in S_RD. Message byte: written with the
// beat; the last one also writes the terminator in S_TERM. Begin: take the beat, walk the
// newest header (S_FA to S_FD), check placement in S_CHK, walk each dropped record (three
// header reads on the single memory read port), write 7 header bytes, a terminator for an
// empty text. Reset: the boot record is written at address 0, no beat taken meanwhile.
// A waiting result does not block the next input beat; a new result waits for it.
module variable_record_ring_log (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // action
  input  logic [1:0]                    s_axis_tuser,
  // record_type[7:0], time_stamp[39:8], msg_length[47:40], msg_byte[55:48],
  // read_addr[67:56], zero pad[71:68]
  input  logic [71:0]                   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status
  output logic [1:0]                    m_axis_tuser,
  // new_block_pos[11:0], oldest_block_pos[23:12], read_data[31:24]
  output logic [31:0]                   m_axis_tdata
);
  import vrrl_pkg::*;

  // Sequencer codes
  localparam logic [3:0] S_INIT = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_FA   = 4'd2;
  localparam logic [3:0] S_FB   = 4'd3;
  localparam logic [3:0] S_FC   = 4'd4;
  localparam logic [3:0] S_FD   = 4'd5;
  localparam logic [3:0] S_CHK  = 4'd6;
  localparam logic [3:0] S_HDR  = 4'd7;
  localparam logic [3:0] S_TERM = 4'd8;
  localparam logic [3:0] S_RD   = 4'd9;
  localparam logic [3:0] S_POST = 4'd10;

  // Input fields
  logic [7:0]        in_type;
  logic [31:0]       in_time;
  logic [7:0]        in_len;
  logic [7:0]        in_byte;
  logic [ADDR_W-1:0] in_addr;

  assign in_type = s_axis_tdata[7:0];
  assign in_time = s_axis_tdata[39:8];
  assign in_len  = s_axis_tdata[47:40];
  assign in_byte = s_axis_tdata[55:48];
  assign in_addr = s_axis_tdata[67:56];

  // Control and payload registers
  logic [3:0]        state;
  logic [4:0]        init_cnt;
  logic [ADDR_W-1:0] first_pos;
  logic [ADDR_W-1:0] last_pos;
  logic [ADDR_W-1:0] cursor;
  logic [7:0]        bytes_left;
  logic              rec_open;
  logic [ADDR_W-1:0] pos;
  logic [ADDR_W-1:0] walk_base;
  logic              walk_first;
  logic [7:0]        walk_type;
  logic [7:0]        len_hi;
  logic [7:0]        last_type;
  logic [STEP_W-1:0] steps;
  logic [2:0]        hdr_cnt;
  logic [7:0]        rtype;
  logic [31:0]       tstamp;
  logic [7:0]        len_r;
  logic [1:0]        stat_r;
  logic [7:0]        rdata_r;

  // Store
  logic [7:0]        store [STORE_BYTES];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [7:0]        mem_rdata;

  logic              accept;
  logic              out_free;
  logic [7:0]        len_cap;
  logic [8:0]        need;
  logic              pos_after;
  logic              fit_end;
  logic              fit_gap;
  logic [ADDR_W-1:0] gap;
  logic [ADDR_W:0]   room_end;
  logic [ADDR_W-1:0] walk_next;
  logic [15:0]       walk_len;
  logic [2:0]        hdr_off;
  logic [8:0]        len_p1;
  logic [7:0]        hdr_byte;
  logic              wrap_mark;

  assign s_axis_tready = (state == S_IDLE);
  assign accept = s_axis_tvalid && s_axis_tready;
  assign out_free = !m_axis_tvalid || m_axis_tready;
  assign len_cap = (in_len > 8'(MSG_MAX)) ? 8'(MSG_MAX) : in_len;
  assign need = {1'b0, len_r} + 9'd9;

  // Placement checks against the store end and the oldest record
  assign pos_after = pos > first_pos;
  assign room_end = (ADDR_W + 1)'(STORE_BYTES) - {1'b0, pos};
  assign fit_end = {{(ADDR_W - 8){1'b0}}, need} < room_end;
  assign gap = first_pos - pos;
  assign fit_gap = {{(ADDR_W - 9){1'b0}}, need} < gap;
  assign wrap_mark = (state == S_CHK) && (steps != '0) && pos_after && !fit_end;

  // Following header position from the walked header
  assign walk_len = {len_hi, mem_rdata};
  assign walk_next = ((walk_type & OVERFLOW_MASK) != 8'h00) ? '0
                   : walk_base + ADDR_W'(8) + walk_len[ADDR_W-1:0];

  // Header byte for the current write slot
  assign hdr_off = (hdr_cnt == 3'd0) ? 3'd0 : hdr_cnt + 3'd1;
  assign len_p1 = {1'b0, len_r} + 9'd1;
  always_comb begin
    case (hdr_cnt)
      3'd0:    hdr_byte = rtype & ~OVERFLOW_MASK;
      3'd1:    hdr_byte = {7'd0, len_p1[8]};
      3'd2:    hdr_byte = len_p1[7:0];
      3'd3:    hdr_byte = tstamp[31:24];
      3'd4:    hdr_byte = tstamp[23:16];
      3'd5:    hdr_byte = tstamp[15:8];
      default: hdr_byte = tstamp[7:0];
    endcase
  end

  // Select the read address
  always_comb begin
    case (state)
      S_IDLE:  mem_raddr = in_addr;
      S_FB:    mem_raddr = walk_base + ADDR_W'(2);
      S_FC:    mem_raddr = walk_base + ADDR_W'(3);
      default: mem_raddr = walk_base;
    endcase
  end

  // Select the write port
  always_comb begin
    mem_we = 1'b0;
    mem_waddr = cursor;
    mem_wdata = 8'h00;
    case (state)
      S_INIT: begin
        mem_we = 1'b1;
        mem_waddr = {{(ADDR_W - 5){1'b0}}, init_cnt};
        mem_wdata = boot_byte(init_cnt);
      end
      S_IDLE: begin
        mem_we = accept && (s_axis_tuser == ACT_MSG) && rec_open;
        mem_wdata = in_byte;
      end
      S_CHK: begin
        mem_we = wrap_mark;
        mem_waddr = last_pos;
        mem_wdata = last_type | OVERFLOW_MASK;
      end
      S_HDR: begin
        mem_we = 1'b1;
        mem_waddr = pos + {{(ADDR_W - 3){1'b0}}, hdr_off};
        mem_wdata = hdr_byte;
      end
      S_TERM: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // Store array with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      store[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= store[mem_raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      init_cnt <= '0;
      first_pos <= '0;
      last_pos <= '0;
      cursor <= '0;
      bytes_left <= '0;
      rec_open <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Drop the result once taken, unless the next one is posted now
      if (m_axis_tvalid && m_axis_tready && state != S_POST) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          init_cnt <= init_cnt + 5'd1;
          if (init_cnt == 5'(BOOT_LAST)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            rdata_r <= 8'h00;
            stat_r <= STAT_ERR;
            state <= S_POST;
            if (s_axis_tuser == ACT_BEGIN && !rec_open) begin
              rtype <= in_type;
              tstamp <= in_time;
              len_r <= len_cap;
              walk_base <= last_pos;
              walk_first <= 1'b0;
              steps <= STEP_W'(STEP_MAX);
              state <= S_FA;
            end else if (s_axis_tuser == ACT_MSG && rec_open) begin
              cursor <= cursor + ADDR_W'(1);
              bytes_left <= bytes_left - 8'd1;
              if (bytes_left == 8'd1) begin
                rec_open <= 1'b0;
                stat_r <= STAT_DONE;
                state <= S_TERM;
              end else begin
                stat_r <= STAT_OPEN;
              end
            end else if (s_axis_tuser == ACT_READ) begin
              stat_r <= STAT_READ;
              state <= S_RD;
            end
          end
        end
        S_FA: begin
          state <= S_FB;
        end
        S_FB: begin
          walk_type <= mem_rdata;
          state <= S_FC;
        end
        S_FC: begin
          len_hi <= mem_rdata;
          state <= S_FD;
        end
        S_FD: begin
          if (walk_first) begin
            first_pos <= walk_next;
          end else begin
            pos <= walk_next;
            last_type <= walk_type;
          end
          state <= S_CHK;
        end
        S_CHK: begin
          hdr_cnt <= 3'd0;
          if (steps == '0) begin
            state <= S_HDR;
          end else begin
            steps <= steps - STEP_W'(1);
            if (pos_after) begin
              if (fit_end) begin
                state <= S_HDR;
              end else begin
                pos <= '0;
              end
            end else if (fit_gap) begin
              state <= S_HDR;
            end else begin
              walk_base <= first_pos;
              walk_first <= 1'b1;
              state <= S_FA;
            end
          end
        end
        S_HDR: begin
          hdr_cnt <= hdr_cnt + 3'd1;
          if (hdr_cnt == 3'd6) begin
            last_pos <= pos;
            cursor <= pos + ADDR_W'(8);
            bytes_left <= len_r;
            if (len_r == 8'd0) begin
              stat_r <= STAT_DONE;
              state <= S_TERM;
            end else begin
              rec_open <= 1'b1;
              stat_r <= STAT_OPEN;
              state <= S_POST;
            end
          end
        end
        S_TERM: begin
          state <= S_POST;
        end
        S_RD: begin
          rdata_r <= mem_rdata;
          state <= S_POST;
        end
        S_POST: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser <= stat_r;
            m_axis_tdata <= {rdata_r, first_pos, last_pos};
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  logic [ADDR_W-1:0] cursor_expect;
  assign cursor_expect = last_pos + ADDR_W'(8) + {{(ADDR_W - 8){1'b0}}, len_r}
                       - {{(ADDR_W - 8){1'b0}}, bytes_left};

  // An open record always expects at least one more text byte
  a_open_has_bytes: assert property (@(posedge clk) disable iff (rst)
    rec_open |-> bytes_left != 8'd0)
    else $error("open record with no bytes left");

  // The write cursor sits inside the newest record's text
  a_cursor_track: assert property (@(posedge clk) disable iff (rst)
    rec_open |-> cursor == cursor_expect)
    else $error("write cursor out of step with newest record");

  // No result leaves and no beat is taken while the boot record is being written
  a_init_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_INIT |-> !m_axis_tvalid && !s_axis_tready)
    else $error("activity during boot record fill");
`endif

endmodule
